// ----- src/chm_pkg.sv -----
// Shared types and codes for the chained hash map engine.
package chm_pkg;

  typedef enum logic [3:0] {
    CMD_GET    = 4'd0,
    CMD_SET    = 4'd1,
    CMD_REMOVE = 4'd2,
    CMD_MULTI  = 4'd3,
    CMD_FNEXT  = 4'd4,
    CMD_COUNT  = 4'd5,
    CMD_RMENT  = 4'd6,
    CMD_RMALL  = 4'd7,
    CMD_CLEAR  = 4'd8
  } cmd_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_BKT,
    S_HEAD,
    S_HEADW,
    S_WALK,
    S_REFRD,
    S_REFW,
    S_ADD,
    S_LINK,
    S_ER1,
    S_LRD,
    S_LWAIT,
    S_MV1,
    S_MV2,
    S_ERDONE,
    S_RESP
  } st_t;

endpackage

// ----- src/chm_mod.sv -----
// Bucket index unit: 64-bit key modulo the bucket count.
module chm_mod
  import chm_pkg::*;
#(
  parameter int BUCKETS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [63:0]                operand,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] rem
);

  localparam int BW = $clog2(BUCKETS);
  localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [32:0] DIVISOR = 33'(BUCKETS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

  // non power of two: four 16-bit digits, multiply by reciprocal then correct
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          phase_r, phase_nxt;
  logic [1:0]    dig_r, dig_nxt;
  logic [63:0]   opnd_r, opnd_nxt;
  logic [31:0]   y_r, y_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [31:0]   y_cur;
  logic [32:0]   qb;
  logic [32:0]   diff;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    dig_nxt   = dig_r;
    opnd_nxt  = opnd_r;
    y_nxt     = y_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    y_cur     = {16'(rem_r), opnd_r[63:48]};
    qb        = 33'(prod_r[63:32]) * DIVISOR;
    diff      = {1'b0, y_r} - qb;
    if (start) begin
      if (IS_POW2) begin
        rem_nxt  = operand[BW-1:0];
        done_nxt = 1'b1;
      end else begin
        opnd_nxt  = operand;
        rem_nxt   = '0;
        dig_nxt   = '0;
        phase_nxt = 1'b0;
        busy_nxt  = 1'b1;
      end
    end else if (busy_r) begin
      if (!phase_r) begin
        y_nxt     = y_cur;
        prod_nxt  = {32'd0, y_cur} * {32'd0, RECIP};
        opnd_nxt  = {opnd_r[47:0], 16'd0};
        phase_nxt = 1'b1;
      end else begin
        if (diff >= DIVISOR) begin
          rem_nxt = BW'(diff - DIVISOR);
        end else begin
          rem_nxt = diff[BW-1:0];
        end
        phase_nxt = 1'b0;
        dig_nxt   = dig_r + 2'd1;
        if (dig_r == 2'd3) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    phase_r <= phase_nxt;
    dig_r   <= dig_nxt;
    opnd_r  <= opnd_nxt;
    y_r     <= y_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- src/chained_hash_map_engine.sv -----
// Chained hash map engine top level: sequencer, bucket and entry memories.
// One command at a time; in_ready is high only while idle. Searching commands walk
// a bucket chain through one entry-memory read port, one entry per cycle;
// the bucket index is the low key bits when BUCKETS is a power of two and
// a digit-serial reciprocal division otherwise. Erases add a second walk
// to relink the moved last entry; remove all repeats search and erase per
// match. After reset, and for clear, a sweep writes every bucket head empty,
// during which no command is taken. A finished result sits in an output
// register, so the next command can start while it waits.
module chained_hash_map_engine
  import chm_pkg::*;
#(
  parameter int BUCKETS     = 1024,
  parameter int ENTRIES     = 512,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_cmd,
  input  logic [63:0] in_key,
  input  logic [31:0] in_value,
  input  logic [8:0]  in_entry_ref,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_value,
  output logic [8:0]  out_found_entry,
  output logic [9:0]  out_match_count
);

  localparam int BW = $clog2(BUCKETS);
  localparam int AW = $clog2(ENTRIES);
  localparam int IW = AW + 1;
  localparam int VW = VALUE_WIDTH;
  localparam logic [IW-1:0] NIL_IDX = {IW{1'b1}};
  localparam logic [IW-1:0] FULL_CNT = IW'(ENTRIES);
  localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

  logic [IW-1:0] heads [BUCKETS];
  logic [63:0]   keys  [ENTRIES];
  logic [VW-1:0] vals  [ENTRIES];
  logic [IW-1:0] links [ENTRIES];

  st_t           state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [IW-1:0] used_r, used_nxt;
  logic [BW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_cmd_r, clr_cmd_nxt;
  logic          moving_r, moving_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [IW-1:0] ref_r, ref_nxt;
  logic [BW-1:0] wb_r, wb_nxt;
  logic [BW-1:0] kb_r, kb_nxt;
  logic [BW-1:0] eb_r, eb_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic [IW-1:0] eidx_r, eidx_nxt;
  logic [IW-1:0] eprev_r, eprev_nxt;
  logic [IW-1:0] enext_r, enext_nxt;
  logic [IW-1:0] ins_link_r, ins_link_nxt;
  logic [63:0]   lk_r, lk_nxt;
  logic [VW-1:0] lv_r, lv_nxt;
  logic [IW-1:0] ll_r, ll_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [VW-1:0] res_val_r, res_val_nxt;
  logic [IW-1:0] res_ent_r, res_ent_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_val_r, out_val_nxt;
  logic [8:0]    out_ent_r, out_ent_nxt;
  logic [9:0]    out_cnt_r, out_cnt_nxt;

  logic [IW-1:0] head_q;
  logic [63:0]   ekey_q;
  logic [VW-1:0] eval_q;
  logic [IW-1:0] elink_q;

  logic          h_we;
  logic [BW-1:0] h_waddr;
  logic [IW-1:0] h_wdata;
  logic          k_we, v_we, l_we;
  logic [AW-1:0] e_waddr, l_waddr, e_raddr;
  logic [63:0]   k_wdata;
  logic [VW-1:0] v_wdata;
  logic [IW-1:0] l_wdata;

  logic          sl_go;
  logic [IW-1:0] sl_prev, sl_tgt;
  logic [BW-1:0] sl_bkt;

  logic          mod_start, mod_done;
  logic [63:0]   mod_operand;
  logic [BW-1:0] mod_rem;

  logic          walk_end, adv, match, idx_mode;
  logic [IW-1:0] elink_n, last_idx;
  logic [VW+31:0]  vin_ext;
  logic [VW+31:0]  vout_ext;
  logic [IW+8:0]   ref_ext;
  logic [IW+8:0]   used_ext;
  logic [IW+8:0]   ent_ext;
  logic [IW+9:0]   cnt_ext;

  chm_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .operand (mod_operand),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  assign mod_operand = (state_r == S_IDLE) ? in_key : ekey_q;
  assign elink_n     = (elink_q >= used_r) ? NIL_IDX : elink_q;
  assign last_idx    = used_r - IW'(1);
  assign idx_mode    = moving_r || (cmd_r == CMD_RMENT);
  assign match       = idx_mode ? (cur_r == tgt_r) : (ekey_q == key_r);
  assign vin_ext     = {{VW{1'b0}}, in_value};
  assign vout_ext    = {32'd0, res_val_r};
  assign ref_ext     = {{IW{1'b0}}, in_entry_ref};
  assign used_ext    = {9'd0, used_r};
  assign ent_ext     = {9'd0, res_ent_r};
  assign cnt_ext     = {10'd0, cnt_r};

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    used_nxt       = used_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_cmd_nxt    = clr_cmd_r;
    moving_nxt     = moving_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    ref_nxt        = ref_r;
    wb_nxt         = wb_r;
    kb_nxt         = kb_r;
    eb_nxt         = eb_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    tgt_nxt        = tgt_r;
    eidx_nxt       = eidx_r;
    eprev_nxt      = eprev_r;
    enext_nxt      = enext_r;
    ins_link_nxt   = ins_link_r;
    lk_nxt         = lk_r;
    lv_nxt         = lv_r;
    ll_nxt         = ll_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    res_ent_nxt    = res_ent_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_ent_nxt    = out_ent_r;
    out_cnt_nxt    = out_cnt_r;
    h_we           = 1'b0;
    h_waddr        = clr_cnt_r;
    h_wdata        = NIL_IDX;
    k_we           = 1'b0;
    v_we           = 1'b0;
    l_we           = 1'b0;
    e_waddr        = used_r[AW-1:0];
    l_waddr        = used_r[AW-1:0];
    k_wdata        = key_r;
    v_wdata        = val_r;
    l_wdata        = ins_link_r;
    e_raddr        = cur_r[AW-1:0];
    sl_go          = 1'b0;
    sl_prev        = prev_r;
    sl_tgt         = res_ent_r;
    sl_bkt         = wb_r;
    mod_start      = 1'b0;
    walk_end       = 1'b0;
    adv            = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        h_we        = 1'b1;
        used_nxt    = '0;
        clr_cnt_nxt = clr_cnt_r + BW'(1);
        if (clr_cnt_r == LAST_BKT) begin
          clr_cnt_nxt = '0;
          if (clr_cmd_r) begin
            res_status_nxt = STAT_OK;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = cmd_t'(in_cmd);
          key_nxt        = in_key;
          val_nxt        = vin_ext[VW-1:0];
          ref_nxt        = ref_ext[IW-1:0];
          res_status_nxt = STAT_MISS;
          res_val_nxt    = '0;
          res_ent_nxt    = '0;
          cnt_nxt        = '0;
          moving_nxt     = 1'b0;
          case (cmd_t'(in_cmd))
            CMD_GET, CMD_SET, CMD_REMOVE, CMD_COUNT, CMD_RMALL: begin
              mod_start = 1'b1;
              state_nxt = S_BKT;
            end
            CMD_MULTI: begin
              if (used_r >= FULL_CNT) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = S_RESP;
              end else begin
                mod_start = 1'b1;
                state_nxt = S_BKT;
              end
            end
            CMD_FNEXT, CMD_RMENT: begin
              if (ref_ext < used_ext) begin
                state_nxt = S_REFRD;
              end else begin
                state_nxt = S_RESP;
              end
            end
            CMD_CLEAR: begin
              clr_cmd_nxt = 1'b1;
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_BKT: begin
        if (mod_done) begin
          wb_nxt = mod_rem;
          if (!moving_r) begin
            kb_nxt = mod_rem;
          end
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: state_nxt = S_HEADW;
      S_HEADW: begin
        prev_nxt = NIL_IDX;
        if (head_q >= used_r) begin
          walk_end = 1'b1;
        end else begin
          e_raddr   = head_q[AW-1:0];
          cur_nxt   = head_q;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (match) begin
          if (moving_r) begin
            state_nxt = S_MV1;
          end else begin
            case (cmd_r)
              CMD_GET, CMD_FNEXT: begin
                res_status_nxt = STAT_OK;
                res_val_nxt    = eval_q;
                res_ent_nxt    = cur_r;
                state_nxt      = S_RESP;
              end
              CMD_SET: begin
                v_we           = 1'b1;
                e_waddr        = cur_r[AW-1:0];
                res_status_nxt = STAT_OK;
                res_val_nxt    = val_r;
                res_ent_nxt    = cur_r;
                state_nxt      = S_RESP;
              end
              CMD_MULTI: begin
                ins_link_nxt = cur_r;
                state_nxt    = S_ADD;
              end
              CMD_REMOVE, CMD_RMENT: begin
                eidx_nxt       = cur_r;
                eprev_nxt      = prev_r;
                eb_nxt         = wb_r;
                enext_nxt      = elink_n;
                res_status_nxt = STAT_OK;
                res_val_nxt    = eval_q;
                res_ent_nxt    = cur_r;
                state_nxt      = S_ER1;
              end
              CMD_RMALL: begin
                eidx_nxt  = cur_r;
                eprev_nxt = prev_r;
                eb_nxt    = wb_r;
                enext_nxt = elink_n;
                cnt_nxt   = cnt_r + IW'(1);
                state_nxt = S_ER1;
              end
              CMD_COUNT: begin
                if (cnt_r == '0) begin
                  res_status_nxt = STAT_OK;
                  res_val_nxt    = eval_q;
                  res_ent_nxt    = cur_r;
                end
                cnt_nxt = cnt_r + IW'(1);
                adv     = 1'b1;
              end
              default: state_nxt = S_RESP;
            endcase
          end
        end else begin
          adv = 1'b1;
        end
        if (adv) begin
          prev_nxt = cur_r;
          if (elink_q >= used_r) begin
            walk_end = 1'b1;
          end else begin
            e_raddr = elink_q[AW-1:0];
            cur_nxt = elink_q;
          end
        end
      end
      S_REFRD: begin
        e_raddr   = ref_r[AW-1:0];
        state_nxt = S_REFW;
      end
      S_REFW: begin
        if (cmd_r == CMD_RMENT) begin
          tgt_nxt   = ref_r;
          mod_start = 1'b1;
          state_nxt = S_BKT;
        end else begin
          key_nxt = ekey_q;
          if (elink_q >= used_r) begin
            state_nxt = S_RESP;
          end else begin
            e_raddr   = elink_q[AW-1:0];
            cur_nxt   = elink_q;
            state_nxt = S_WALK;
          end
        end
      end
      S_ADD: begin
        k_we           = 1'b1;
        v_we           = 1'b1;
        l_we           = 1'b1;
        res_status_nxt = STAT_OK;
        res_val_nxt    = val_r;
        res_ent_nxt    = used_r;
        used_nxt       = used_r + IW'(1);
        state_nxt      = S_LINK;
      end
      S_LINK: begin
        sl_go     = 1'b1;
        state_nxt = S_RESP;
      end
      S_ER1: begin
        sl_go   = 1'b1;
        sl_prev = eprev_r;
        sl_tgt  = enext_r;
        sl_bkt  = eb_r;
        if (eidx_r == last_idx) begin
          state_nxt = S_ERDONE;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        e_raddr   = last_idx[AW-1:0];
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        lk_nxt     = ekey_q;
        lv_nxt     = eval_q;
        ll_nxt     = elink_q;
        tgt_nxt    = last_idx;
        moving_nxt = 1'b1;
        mod_start  = 1'b1;
        state_nxt  = S_BKT;
      end
      S_MV1: begin
        k_we      = 1'b1;
        v_we      = 1'b1;
        l_we      = 1'b1;
        e_waddr   = eidx_r[AW-1:0];
        l_waddr   = eidx_r[AW-1:0];
        k_wdata   = lk_r;
        v_wdata   = lv_r;
        l_wdata   = ll_r;
        state_nxt = S_MV2;
      end
      S_MV2: begin
        sl_go     = 1'b1;
        sl_tgt    = eidx_r;
        state_nxt = S_ERDONE;
      end
      S_ERDONE: begin
        used_nxt   = last_idx;
        moving_nxt = 1'b0;
        if (cmd_r == CMD_RMALL) begin
          wb_nxt    = kb_r;
          state_nxt = S_HEAD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt    = vout_ext[31:0];
          out_ent_nxt    = ent_ext[8:0];
          out_cnt_nxt    = (cmd_r == CMD_COUNT || cmd_r == CMD_RMALL) ? cnt_ext[9:0] : 10'd0;
          clr_cmd_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (walk_end) begin
      if (moving_r) begin
        state_nxt = S_ERDONE;
      end else begin
        case (cmd_r)
          CMD_SET: begin
            if (used_r >= FULL_CNT) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = S_RESP;
            end else begin
              ins_link_nxt = NIL_IDX;
              state_nxt    = S_ADD;
            end
          end
          CMD_MULTI: begin
            ins_link_nxt = NIL_IDX;
            state_nxt    = S_ADD;
          end
          CMD_RMALL, CMD_COUNT: begin
            res_status_nxt = (cnt_nxt != '0) ? STAT_OK : STAT_MISS;
            state_nxt      = S_RESP;
          end
          default: state_nxt = S_RESP;
        endcase
      end
    end

    if (sl_go) begin
      if (sl_prev == NIL_IDX) begin
        h_we    = 1'b1;
        h_waddr = sl_bkt;
        h_wdata = sl_tgt;
      end else begin
        l_we    = 1'b1;
        l_waddr = sl_prev[AW-1:0];
        l_wdata = sl_tgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      heads[h_waddr] <= h_wdata;
    end
    if (k_we) begin
      keys[e_waddr] <= k_wdata;
    end
    if (v_we) begin
      vals[e_waddr] <= v_wdata;
    end
    if (l_we) begin
      links[l_waddr] <= l_wdata;
    end
    head_q  <= heads[wb_r];
    ekey_q  <= keys[e_raddr];
    eval_q  <= vals[e_raddr];
    elink_q <= links[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      used_r      <= '0;
      clr_cnt_r   <= '0;
      clr_cmd_r   <= 1'b0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      moving_r    <= moving_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    ref_r        <= ref_nxt;
    wb_r         <= wb_nxt;
    kb_r         <= kb_nxt;
    eb_r         <= eb_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    tgt_r        <= tgt_nxt;
    eidx_r       <= eidx_nxt;
    eprev_r      <= eprev_nxt;
    enext_r      <= enext_nxt;
    ins_link_r   <= ins_link_nxt;
    lk_r         <= lk_nxt;
    lv_r         <= lv_nxt;
    ll_r         <= ll_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_ent_r    <= out_ent_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_val_r;
  assign out_found_entry = out_ent_r;
  assign out_match_count = out_cnt_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_CNT) else $error("entry count above capacity");
  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_BKT) else $error("bucket index done outside wait");
  a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> used_r < FULL_CNT) else $error("append into full table");
  a_erase_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ER1 |-> eidx_r < used_r) else $error("erase of unused entry");
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken while busy");

endmodule

// ----- sim/tb_chained_hash_map_engine.sv -----
// Self-checking testbench for the chained hash map engine.
`timescale 1ns / 1ps

module tb_chained_hash_map_engine;
  import chm_pkg::*;

  localparam int NB = 1024;
  localparam int NE = 512;
  localparam int NIL = -1;
  localparam int LIMIT = 3000000;
  localparam int HOLD_START = 4000;
  localparam int HOLD_LEN = 3000;

  typedef struct {
    logic [3:0]  cmd;
    logic [63:0] key;
    logic [31:0] value;
    logic [8:0]  eref;
  } cmd_beat_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] fval;
    logic [8:0]  fent;
    logic [9:0]  cnt;
  } rsp_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_cmd;
  logic [63:0] in_key;
  logic [31:0] in_value;
  logic [8:0]  in_entry_ref;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_found_value;
  logic [8:0]  out_found_entry;
  logic [9:0]  out_match_count;

  cmd_beat_t pend_cmds[$];
  rsp_beat_t exp_rsps[$];
  int        errs;
  int        cyc;
  int        in_gap;
  int        out_gap;
  bit        gen_done;

  // shadow table
  int          heads[NB];
  logic [63:0] ekey[NE];
  logic [31:0] evalue[NE];
  int          elink[NE];
  int          used;
  logic [63:0] key_pool[32];

  chained_hash_map_engine u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int next_of(int i);
    if (i < 0 || i >= used) return NIL;
    return (elink[i] >= 0 && elink[i] < used) ? elink[i] : NIL;
  endfunction

  function automatic int head_of(int b);
    return (heads[b] >= 0 && heads[b] < used) ? heads[b] : NIL;
  endfunction

  function automatic void set_link(int prev, int b, int t);
    if (prev == NIL) heads[b] = t;
    else elink[prev] = t;
  endfunction

  function automatic void find_key(logic [63:0] k, output int b, output int prev,
                                   output int idx);
    int steps;
    int p;
    int i;
    steps = 0;
    p = NIL;
    b = int'(k[9:0]);
    i = head_of(b);
    while (i != NIL && steps < NE) begin
      if (ekey[i] == k) break;
      p = i;
      i = next_of(i);
      steps++;
    end
    if (steps >= NE) i = NIL;
    prev = p;
    idx = i;
  endfunction

  function automatic bit find_entry(int e, output int b, output int prev);
    int steps;
    int p;
    int i;
    steps = 0;
    p = NIL;
    prev = NIL;
    b = int'(ekey[e][9:0]);
    i = head_of(b);
    while (i != NIL && steps < NE) begin
      if (i == e) begin
        prev = p;
        return 1'b1;
      end
      p = i;
      i = next_of(i);
      steps++;
    end
    return 1'b0;
  endfunction

  function automatic void erase_slot(int b, int prev, int idx);
    int last;
    int lb;
    int lprev;
    set_link(prev, b, next_of(idx));
    last = used - 1;
    if (idx != last && find_entry(last, lb, lprev)) begin
      set_link(lprev, lb, idx);
      ekey[idx] = ekey[last];
      evalue[idx] = evalue[last];
      elink[idx] = elink[last];
    end
    used = last;
  endfunction

  function automatic int append_slot(logic [63:0] k, logic [31:0] v, int lnk);
    int i;
    i = used;
    ekey[i] = k;
    evalue[i] = v;
    elink[i] = lnk;
    used = i + 1;
    return i;
  endfunction

  function automatic rsp_beat_t predict_rsp(cmd_beat_t c);
    rsp_beat_t r;
    int b;
    int prev;
    int idx;
    int i;
    int steps;
    int n;
    int rf;
    r.status = STAT_MISS;
    r.fval = '0;
    r.fent = '0;
    r.cnt = '0;
    n = 0;
    rf = int'(c.eref);
    case (c.cmd)
      CMD_GET: begin
        find_key(c.key, b, prev, idx);
        if (idx != NIL) begin
          r.status = STAT_OK; r.fval = evalue[idx]; r.fent = idx[8:0];
        end
      end
      CMD_SET: begin
        find_key(c.key, b, prev, idx);
        if (idx != NIL) begin
          evalue[idx] = c.value;
          r.status = STAT_OK; r.fval = c.value; r.fent = idx[8:0];
        end else if (used >= NE) begin
          r.status = STAT_FULL;
        end else begin
          idx = append_slot(c.key, c.value, NIL);
          set_link(prev, b, idx);
          r.status = STAT_OK; r.fval = c.value; r.fent = idx[8:0];
        end
      end
      CMD_REMOVE: begin
        find_key(c.key, b, prev, idx);
        if (idx != NIL) begin
          r.status = STAT_OK; r.fval = evalue[idx]; r.fent = idx[8:0];
          erase_slot(b, prev, idx);
        end
      end
      CMD_MULTI: begin
        if (used >= NE) begin
          r.status = STAT_FULL;
        end else begin
          find_key(c.key, b, prev, idx);
          idx = append_slot(c.key, c.value, idx);
          set_link(prev, b, idx);
          r.status = STAT_OK; r.fval = c.value; r.fent = idx[8:0];
        end
      end
      CMD_FNEXT: begin
        if (rf < used) begin
          steps = 0;
          i = next_of(rf);
          while (i != NIL && steps < NE) begin
            if (ekey[i] == ekey[rf]) begin
              r.status = STAT_OK; r.fval = evalue[i]; r.fent = i[8:0];
              break;
            end
            i = next_of(i);
            steps++;
          end
        end
      end
      CMD_COUNT: begin
        steps = 0;
        i = head_of(int'(c.key[9:0]));
        while (i != NIL && steps < NE) begin
          if (ekey[i] == c.key) begin
            if (n == 0) begin
              r.status = STAT_OK; r.fval = evalue[i]; r.fent = i[8:0];
            end
            n++;
          end
          i = next_of(i);
          steps++;
        end
      end
      CMD_RMENT: begin
        if (rf < used && find_entry(rf, b, prev)) begin
          r.status = STAT_OK; r.fval = evalue[rf]; r.fent = c.eref;
          erase_slot(b, prev, rf);
        end
      end
      CMD_RMALL: begin
        forever begin
          find_key(c.key, b, prev, idx);
          if (idx == NIL) break;
          erase_slot(b, prev, idx);
          n++;
        end
        r.status = (n > 0) ? STAT_OK : STAT_MISS;
      end
      CMD_CLEAR: begin
        for (i = 0; i < NB; i++) heads[i] = NIL;
        used = 0;
        r.status = STAT_OK;
      end
      default: ;
    endcase
    r.cnt = n[9:0];
    return r;
  endfunction

  task automatic queue_cmd(logic [3:0] cmd, logic [63:0] k, logic [31:0] v, logic [8:0] rf);
    cmd_beat_t c;
    c.cmd = cmd;
    c.key = k;
    c.value = v;
    c.eref = rf;
    exp_rsps.push_back(predict_rsp(c));
    pend_cmds.push_back(c);
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 31)];
  endfunction

  function automatic logic [8:0] pick_ref();
    if (used > 0 && $urandom_range(0, 6) != 0) return 9'($urandom_range(0, used - 1));
    return 9'($urandom_range(0, 511));
  endfunction

  task automatic queue_random();
    int r;
    logic [3:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 25) cmd = CMD_SET;
    else if (r < 40) cmd = CMD_MULTI;
    else if (r < 50) cmd = CMD_GET;
    else if (r < 58) cmd = CMD_REMOVE;
    else if (r < 66) cmd = CMD_FNEXT;
    else if (r < 74) cmd = CMD_COUNT;
    else if (r < 84) cmd = CMD_RMENT;
    else if (r < 90) cmd = CMD_RMALL;
    else if (r < 92) cmd = CMD_CLEAR;
    else if (r < 95) cmd = 4'($urandom_range(9, 15));
    else cmd = 4'($urandom_range(0, 15));
    queue_cmd(cmd, pick_key(), $urandom, pick_ref());
  endtask

  // stimulus and expected responses
  initial begin
    logic [63:0] kmax;
    logic [63:0] kcol;
    logic [9:0]  low_set[4];
    gen_done = 1'b0;
    for (int i = 0; i < NB; i++) heads[i] = NIL;
    for (int i = 0; i < NE; i++) begin
      ekey[i] = '0; evalue[i] = '0; elink[i] = 0;
    end
    used = 0;
    low_set[0] = 10'd0; low_set[1] = 10'd1; low_set[2] = 10'h3ff; low_set[3] = 10'd5;
    for (int i = 0; i < 32; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][9:0] = low_set[i % 4];
    end
    kmax = '1;
    kcol = {32'h0, 32'h3ff};

    queue_cmd(CMD_GET, kmax, 32'h0, 9'h0);
    queue_cmd(CMD_SET, kmax, 32'hffffffff, 9'h0);
    queue_cmd(CMD_SET, 64'h0, 32'h0, 9'h1ff);
    queue_cmd(CMD_SET, kcol, 32'h1234, 9'h0);
    queue_cmd(CMD_GET, kcol, 32'h0, 9'h0);
    queue_cmd(CMD_SET, kmax, 32'h5a5a5a5a, 9'h0);
    queue_cmd(CMD_MULTI, kmax, 32'h1, 9'h0);
    queue_cmd(CMD_MULTI, kcol, 32'h2, 9'h0);
    queue_cmd(CMD_MULTI, kmax, 32'h3, 9'h0);
    queue_cmd(CMD_FNEXT, 64'h0, 32'h0, 9'd4);
    queue_cmd(CMD_FNEXT, 64'h0, 32'h0, 9'd1);
    queue_cmd(CMD_FNEXT, 64'h0, 32'h0, 9'h1ff);
    queue_cmd(CMD_COUNT, kmax, 32'h0, 9'h0);
    queue_cmd(CMD_COUNT, 64'h7ff, 32'h0, 9'h0);
    queue_cmd(CMD_REMOVE, kmax, 32'h0, 9'h0);
    queue_cmd(CMD_REMOVE, 64'h3, 32'h0, 9'h0);
    queue_cmd(CMD_RMENT, 64'h0, 32'h0, 9'd0);
    queue_cmd(CMD_RMENT, 64'h0, 32'h0, 9'h1ff);
    queue_cmd(CMD_RMALL, kmax, 32'h0, 9'h0);
    queue_cmd(CMD_RMALL, kmax, 32'h0, 9'h0);
    queue_cmd(4'hf, kmax, 32'hffffffff, 9'h1ff);
    queue_cmd(4'h9, 64'h0, 32'h0, 9'h0);
    queue_cmd(CMD_CLEAR, 64'h0, 32'h0, 9'h0);
    queue_cmd(CMD_GET, 64'h0, 32'h0, 9'h0);

    for (int i = 0; i < 40; i++) queue_random();
    while (used < NE) begin
      if ($urandom_range(0, 4) != 0)
        queue_cmd(CMD_MULTI, pick_key(), $urandom, pick_ref());
      else
        queue_cmd(CMD_SET, {$urandom, $urandom}, $urandom, pick_ref());
    end
    for (int i = 0; i < 6; i++) queue_cmd(CMD_MULTI, pick_key(), $urandom, 9'h0);
    for (int i = 0; i < 6; i++) queue_cmd(CMD_SET, {$urandom, $urandom}, $urandom, 9'h0);
    queue_cmd(CMD_FNEXT, 64'h0, 32'h0, 9'h1ff);
    queue_cmd(CMD_RMENT, 64'h0, 32'h0, 9'h1ff);
    for (int i = 0; i < 40; i++) queue_random();
    gen_done = 1'b1;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_cmd <= '0;
      in_key <= '0;
      in_value <= '0;
      in_entry_ref <= '0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pend_cmds.size() != 0) begin
        in_cmd <= pend_cmds[0].cmd;
        in_key <= pend_cmds[0].key;
        in_value <= pend_cmds[0].value;
        in_entry_ref <= pend_cmds[0].eref;
        void'(pend_cmds.pop_front());
        in_valid <= 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_rsps.size() == 0) begin
          $error("unexpected result beat");
          errs++;
        end else begin
          if (out_status !== exp_rsps[0].status) begin
            $error("status exp %0d got %0d", exp_rsps[0].status, out_status);
            errs++;
          end
          if (out_found_value !== exp_rsps[0].fval) begin
            $error("found_value exp %0h got %0h", exp_rsps[0].fval, out_found_value);
            errs++;
          end
          if (out_found_entry !== exp_rsps[0].fent) begin
            $error("found_entry exp %0d got %0d", exp_rsps[0].fent, out_found_entry);
            errs++;
          end
          if (out_match_count !== exp_rsps[0].cnt) begin
            $error("match_count exp %0d got %0d", exp_rsps[0].cnt, out_match_count);
            errs++;
          end
          void'(exp_rsps.pop_front());
        end
      end
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    errs = 0;
    cyc = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (gen_done);
    while (pend_cmds.size() != 0 || in_valid || exp_rsps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
